/* hw/rtl/tts_pkg.sv */
`timescale 1ns / 1ps

package tts_pkg;

   // coordinate format: signed fixed point, fixed by the interface
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

   // input vertex indices
   localparam logic [1:0] VERT_A = 2'd0;
   localparam logic [1:0] VERT_B = 2'd1;
   localparam logic [1:0] VERT_C = 2'd2;

   // trapezoid counts
   localparam logic [1:0] COUNT_NONE  = 2'd0;
   localparam logic [1:0] COUNT_FLAT  = 2'd1;
   localparam logic [1:0] COUNT_SPLIT = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef enum logic [1:0] {
      KIND_DEGEN,
      KIND_FLAT_TOP,
      KIND_FLAT_BOT,
      KIND_SPLIT
   } kind_type;

   typedef struct packed {
      coord_type vert_a_x;
      coord_type vert_a_y;
      coord_type vert_b_x;
      coord_type vert_b_y;
      coord_type vert_c_x;
      coord_type vert_c_y;
   } req_type;

   typedef struct packed {
      logic [1:0] trap_count;
      coord_type  top_y;
      coord_type  bottom_y;
      logic [1:0] left_start;
      logic [1:0] left_end;
      logic [1:0] right_start;
      logic [1:0] right_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      logic [1:0] idx;
   } vert_type;

   // vertices after the y sort
   typedef struct packed {
      vert_type v1;
      vert_type v2;
      vert_type v3;
   } sort_type;

   // classified triangle with edge deltas
   typedef struct packed {
      kind_type   kind;
      coord_type  y1;
      coord_type  y2;
      coord_type  y3;
      logic [1:0] i1;
      logic [1:0] i2;
      logic [1:0] i3;
      diff_type   dx31;
      diff_type   dx21;
      diff_type   dy21;
      diff_type   dy31;
   } delta_type;

   // classified triangle with side-test products
   typedef struct packed {
      kind_type   kind;
      coord_type  y1;
      coord_type  y2;
      coord_type  y3;
      logic [1:0] i1;
      logic [1:0] i2;
      logic [1:0] i3;
      prod_type   p_long;
      prod_type   p_mid;
   } edge_type;

endpackage

/* hw/rtl/tts_sort.sv */
`timescale 1ns / 1ps

module tts_sort (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  tts_pkg::req_type in_data,
   output logic             out_valid,
   output tts_pkg::sort_type out_data
);
   import tts_pkg::*;

   logic     valid_ff;
   sort_type data_ff;
   sort_type data_in;

   // three compare-swaps on y: (1,2), (1,3), (2,3); equal y values are not swapped
   always_comb begin
      vert_type a;
      vert_type b;
      vert_type c;
      vert_type t;
      a = '{x: in_data.vert_a_x, y: in_data.vert_a_y, idx: VERT_A};
      b = '{x: in_data.vert_b_x, y: in_data.vert_b_y, idx: VERT_B};
      c = '{x: in_data.vert_c_x, y: in_data.vert_c_y, idx: VERT_C};
      t = a;
      if (a.y > b.y) begin
         t = a; a = b; b = t;
      end
      if (a.y > c.y) begin
         t = a; a = c; c = t;
      end
      if (b.y > c.y) begin
         t = b; b = c; c = t;
      end
      data_in = '{v1: a, v2: b, v3: c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/tts_edge.sv */
`timescale 1ns / 1ps

module tts_edge (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  tts_pkg::sort_type in_data,
   output logic              out_valid,
   output tts_pkg::edge_type out_data
);
   import tts_pkg::*;

   logic      delta_valid_ff;
   delta_type delta_ff;
   delta_type delta_in;
   logic      edge_valid_ff;
   edge_type  edge_ff;
   edge_type  edge_in;

   // classify and take edge deltas
   always_comb begin
      vert_type v1;
      vert_type v2;
      vert_type v3;
      vert_type t;
      kind_type kind;
      v1 = in_data.v1;
      v2 = in_data.v2;
      v3 = in_data.v3;
      t  = v1;
      if ((v1.y == v2.y && v1.y == v3.y) || (v1.x == v2.x && v1.x == v3.x)) begin
         kind = KIND_DEGEN;
      end else if (v1.y == v2.y) begin
         kind = KIND_FLAT_TOP;
         if (v1.x > v2.x) begin
            t = v1; v1 = v2; v2 = t;
         end
      end else if (v2.y == v3.y) begin
         kind = KIND_FLAT_BOT;
         if (v2.x > v3.x) begin
            t = v2; v2 = v3; v3 = t;
         end
      end else begin
         kind = KIND_SPLIT;
      end
      delta_in.kind = kind;
      delta_in.y1   = v1.y;
      delta_in.y2   = v2.y;
      delta_in.y3   = v3.y;
      delta_in.i1   = v1.idx;
      delta_in.i2   = v2.idx;
      delta_in.i3   = v3.idx;
      delta_in.dx31 = DIFF_WIDTH'(v3.x) - DIFF_WIDTH'(v1.x);
      delta_in.dx21 = DIFF_WIDTH'(v2.x) - DIFF_WIDTH'(v1.x);
      delta_in.dy21 = DIFF_WIDTH'(v2.y) - DIFF_WIDTH'(v1.y);
      delta_in.dy31 = DIFF_WIDTH'(v3.y) - DIFF_WIDTH'(v1.y);
   end

   // side test products: long edge (x3-x1)*(y2-y1), middle (x2-x1)*(y3-y1)
   always_comb begin
      edge_in.kind   = delta_ff.kind;
      edge_in.y1     = delta_ff.y1;
      edge_in.y2     = delta_ff.y2;
      edge_in.y3     = delta_ff.y3;
      edge_in.i1     = delta_ff.i1;
      edge_in.i2     = delta_ff.i2;
      edge_in.i3     = delta_ff.i3;
      edge_in.p_long = PROD_WIDTH'(delta_ff.dx31) * PROD_WIDTH'(delta_ff.dy21);
      edge_in.p_mid  = PROD_WIDTH'(delta_ff.dx21) * PROD_WIDTH'(delta_ff.dy31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_valid_ff <= 1'b0;
         edge_valid_ff  <= 1'b0;
      end else if (advance) begin
         delta_valid_ff <= in_valid;
         edge_valid_ff  <= delta_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff <= delta_in;
         edge_ff  <= edge_in;
      end
   end

   assign out_valid = edge_valid_ff;
   assign out_data  = edge_ff;

endmodule

/* hw/rtl/tts_emit.sv */
`timescale 1ns / 1ps

module tts_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tts_pkg::edge_type in_data,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tts_pkg::rsp_type  rsp_data
);
   import tts_pkg::*;

   typedef struct packed {
      kind_type   kind;
      logic       right;
      coord_type  y1;
      coord_type  y2;
      coord_type  y3;
      logic [1:0] i1;
      logic [1:0] i2;
      logic [1:0] i3;
   } hold_type;

   logic     valid_ff;
   logic     valid_in;
   logic     phase_ff;
   logic     phase_in;
   hold_type hold_ff;
   hold_type hold_in;
   logic     xfer;

   // long edge on the right when at or right of the middle vertex
   always_comb begin
      hold_in.kind  = in_data.kind;
      hold_in.right = (in_data.p_long >= in_data.p_mid);
      hold_in.y1    = in_data.y1;
      hold_in.y2    = in_data.y2;
      hold_in.y3    = in_data.y3;
      hold_in.i1    = in_data.i1;
      hold_in.i2    = in_data.i2;
      hold_in.i3    = in_data.i3;
   end

   // result fields for the held triangle and the current phase
   always_comb begin
      rsp_data = '0;
      rsp_data.last = 1'b1;
      case (hold_ff.kind)
         KIND_DEGEN: begin
            rsp_data.trap_count = COUNT_NONE;
         end
         KIND_FLAT_TOP: begin
            rsp_data.trap_count  = COUNT_FLAT;
            rsp_data.top_y       = hold_ff.y1;
            rsp_data.bottom_y    = hold_ff.y3;
            rsp_data.left_start  = hold_ff.i1;
            rsp_data.left_end    = hold_ff.i3;
            rsp_data.right_start = hold_ff.i2;
            rsp_data.right_end   = hold_ff.i3;
         end
         KIND_FLAT_BOT: begin
            rsp_data.trap_count  = COUNT_FLAT;
            rsp_data.top_y       = hold_ff.y1;
            rsp_data.bottom_y    = hold_ff.y3;
            rsp_data.left_start  = hold_ff.i1;
            rsp_data.left_end    = hold_ff.i2;
            rsp_data.right_start = hold_ff.i1;
            rsp_data.right_end   = hold_ff.i3;
         end
         KIND_SPLIT: begin
            rsp_data.trap_count = COUNT_SPLIT;
            if (!phase_ff) begin
               // upper half, down to the middle vertex
               rsp_data.last     = 1'b0;
               rsp_data.top_y    = hold_ff.y1;
               rsp_data.bottom_y = hold_ff.y2;
               rsp_data.left_start  = hold_ff.i1;
               rsp_data.right_start = hold_ff.i1;
               if (hold_ff.right) begin
                  rsp_data.left_end  = hold_ff.i2;
                  rsp_data.right_end = hold_ff.i3;
               end else begin
                  rsp_data.left_end  = hold_ff.i3;
                  rsp_data.right_end = hold_ff.i2;
               end
            end else begin
               // lower half, from the middle vertex
               rsp_data.top_y    = hold_ff.y2;
               rsp_data.bottom_y = hold_ff.y3;
               rsp_data.left_end  = hold_ff.i3;
               rsp_data.right_end = hold_ff.i3;
               if (hold_ff.right) begin
                  rsp_data.left_start  = hold_ff.i2;
                  rsp_data.right_start = hold_ff.i1;
               end else begin
                  rsp_data.left_start  = hold_ff.i1;
                  rsp_data.right_start = hold_ff.i2;
               end
            end
         end
         default: begin
            rsp_data.trap_count = COUNT_NONE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign xfer      = valid_ff && !rsp_stall;
   // pipeline moves when the holding register is empty or frees up now
   assign advance   = !valid_ff || (xfer && rsp_data.last);

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (advance) begin
         valid_in = in_valid;
         phase_in = 1'b0;
      end else if (xfer) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hold_ff <= hold_in;
      end
   end

   // second phase only exists for a held split triangle
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (valid_ff && hold_ff.kind == KIND_SPLIT))
      else $error("second phase without a held split triangle");

   // a first-half transfer is always followed by the second half
   assert property (@(posedge clock) disable iff (reset)
      (xfer && !rsp_data.last) |=> (valid_ff && phase_ff))
      else $error("split triangle lost its second trapezoid");

   // a new triangle always starts at the first phase
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid) |=> !phase_ff)
      else $error("new triangle loaded in second phase");

   // nothing is presented right after reset
   assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result valid after reset");

endmodule

/* hw/rtl/triangle_trapezoid_setup_unit.sv */
`timescale 1ns / 1ps
// Pipeline: four register stages (sort, delta, edge product, emit hold); the result is
// presented from the emit hold register and transfers when rsp_stall is low.
// Rate: one triangle per cycle for degenerate and flat triangles while rsp_stall is low;
// a split triangle holds the pipeline while the single result register emits both halves.
// A stalled result freezes all four stages in place; nothing is dropped or repeated.
// Reset (synchronous) clears every stage valid bit and the emit phase; no state else.
module triangle_trapezoid_setup_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tts_pkg::rsp_type rsp_data
);
   import tts_pkg::*;

   logic     advance;
   logic     sort_valid;
   sort_type sort_data;
   logic     edge_valid;
   edge_type edge_data;

   // y sort
   tts_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (sort_valid),
      .out_data  (sort_data)
   );

   // classification, deltas and side-test products
   tts_edge u_edge (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sort_valid),
      .in_data   (sort_data),
      .out_valid (edge_valid),
      .out_data  (edge_data)
   );

   // side decision and trapezoid output
   tts_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (edge_valid),
      .in_data   (edge_data),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !advance;

endmodule
